// File: rtl/core/dfusm_pkg.sv
// Shared types, codes and parameter defaults for the DFU download state machine.
// Used by every module under rtl/core; depends on nothing.
package dfusm_pkg;

    localparam int unsigned MAX_BLOCK_LEN_DEF = 1024;
    localparam int unsigned HEADER_SIZE_DEF   = 32;

    // DFU class request codes
    localparam logic [7:0] REQ_DNLOAD    = 8'd1;
    localparam logic [7:0] REQ_GETSTATUS = 8'd3;
    localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
    localparam logic [7:0] REQ_GETSTATE  = 8'd5;
    localparam logic [7:0] REQ_ABORT     = 8'd6;

    // minimum wLength of the reads
    localparam logic [15:0] GETSTATUS_MIN_LEN = 16'd6;
    localparam logic [15:0] GETSTATE_MIN_LEN  = 16'd1;

    localparam logic [3:0] FLASH_OK = 4'd0;

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_DN_SYNC    = 3'd1,
        ST_DN_IDLE    = 3'd2,
        ST_MAN_SYNC   = 3'd3,
        ST_MAN        = 3'd4,
        ST_WAIT_RESET = 3'd5,
        ST_ERROR      = 3'd6
    } dfu_phase_t;

    typedef enum logic [3:0] {
        SC_OK       = 4'd0,
        SC_TARGET   = 4'd1,
        SC_FILE     = 4'd2,
        SC_WRITE    = 4'd3,
        SC_ERASE    = 4'd4,
        SC_VERIFY   = 4'd5,
        SC_ADDRESS  = 4'd6,
        SC_FIRMWARE = 4'd7,
        SC_SEQUENCE = 4'd8,
        SC_UNKNOWN  = 4'd9
    } status_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic        direction_in;
        logic        class_interface_ok;
        logic [15:0] block_number;
        logic [15:0] length;
        logic [3:0]  flash_result;
    } req_t;

    typedef struct packed {
        logic       accepted;
        logic [3:0] status_code;
        logic [2:0] state_code;
        logic       manifest_done;
    } rsp_t;

    // flash engine verdict to DFU status
    function automatic status_t flash_to_status(input logic [3:0] fres);
        status_t sc;
        case (fres)
            4'd0:    sc = SC_OK;
            4'd1:    sc = SC_ADDRESS;
            4'd2:    sc = SC_VERIFY;
            4'd3:    sc = SC_VERIFY;
            4'd4:    sc = SC_FIRMWARE;
            4'd5:    sc = SC_ERASE;
            4'd6:    sc = SC_WRITE;
            4'd7:    sc = SC_SEQUENCE;
            default: sc = SC_FIRMWARE;
        endcase
        return sc;
    endfunction

endpackage

// File: rtl/core/dfusm_in_reg.sv
// Input register for request items.
// Depends on dfusm_pkg for the request item type.
module dfusm_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  dfusm_pkg::req_t  req,
    input  logic             advance,
    output logic             item_vld,
    output dfusm_pkg::req_t  item
);

    logic            vld_reg;
    logic            vld_next;
    logic            take;
    dfusm_pkg::req_t item_reg;

    // hold while the register is full and not moving on
    assign req_stall = vld_reg && !advance;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= req;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

// File: rtl/core/dfusm_ctrl.sv
// DFU state, sticky status, header and manifest flags, write offset.
// Depends on dfusm_pkg for codes, item types and the flash status mapping.
module dfusm_ctrl
#(
    parameter int unsigned MAX_BLOCK_LEN = dfusm_pkg::MAX_BLOCK_LEN_DEF,
    parameter int unsigned HEADER_SIZE   = dfusm_pkg::HEADER_SIZE_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dfusm_pkg::req_t  item,
    output dfusm_pkg::rsp_t  result
);

    localparam logic [15:0] XFER_LEN = 16'(MAX_BLOCK_LEN);
    localparam logic [15:0] HDR_LEN  = 16'(HEADER_SIZE);

    dfusm_pkg::dfu_phase_t state_reg, state_next;
    dfusm_pkg::status_t    status_reg, status_next;
    logic                  hdr_reg, hdr_next;
    logic                  man_reg, man_next;
    logic [23:0]           off_reg, off_next;

    logic [15:0] blk_m1;
    logic [31:0] expect_off;
    logic        offset_match;
    logic        can_abort;
    logic        ok;

    assign blk_m1       = item.block_number - 16'd1;
    assign expect_off   = 32'(blk_m1) * 32'(MAX_BLOCK_LEN);
    assign offset_match = (expect_off == {8'd0, off_reg});
    assign can_abort    = (state_reg == dfusm_pkg::ST_IDLE)
                       || (state_reg == dfusm_pkg::ST_DN_SYNC)
                       || (state_reg == dfusm_pkg::ST_DN_IDLE);

    // next state
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        hdr_next    = hdr_reg;
        man_next    = man_reg;
        off_next    = off_reg;
        if (fire && item.class_interface_ok)
        begin
            case (item.kind)
                dfusm_pkg::REQ_DNLOAD:
                begin
                    if (!item.direction_in && state_reg != dfusm_pkg::ST_ERROR)
                    begin
                        if (item.length == 16'd0)
                        begin
                            if (state_reg != dfusm_pkg::ST_DN_IDLE || !hdr_reg)
                            begin
                                state_next  = dfusm_pkg::ST_ERROR;
                                status_next = dfusm_pkg::SC_SEQUENCE;
                            end
                            else
                            begin
                                state_next = dfusm_pkg::ST_MAN_SYNC;
                            end
                        end
                        else if (item.length <= XFER_LEN)
                        begin
                            if (item.block_number == 16'd0)
                            begin
                                if (item.length != HDR_LEN || hdr_reg)
                                begin
                                    state_next  = dfusm_pkg::ST_ERROR;
                                    status_next = dfusm_pkg::SC_SEQUENCE;
                                end
                                else
                                begin
                                    status_next = dfusm_pkg::flash_to_status(item.flash_result);
                                    if (item.flash_result != dfusm_pkg::FLASH_OK)
                                    begin
                                        state_next = dfusm_pkg::ST_ERROR;
                                    end
                                    else
                                    begin
                                        hdr_next   = 1'b1;
                                        off_next   = '0;
                                        state_next = dfusm_pkg::ST_DN_SYNC;
                                    end
                                end
                            end
                            else if (!hdr_reg || !offset_match)
                            begin
                                state_next  = dfusm_pkg::ST_ERROR;
                                status_next = dfusm_pkg::SC_SEQUENCE;
                            end
                            else
                            begin
                                status_next = dfusm_pkg::flash_to_status(item.flash_result);
                                if (item.flash_result != dfusm_pkg::FLASH_OK)
                                begin
                                    state_next = dfusm_pkg::ST_ERROR;
                                end
                                else
                                begin
                                    off_next   = off_reg + 24'(item.length);
                                    state_next = dfusm_pkg::ST_DN_SYNC;
                                end
                            end
                        end
                    end
                end
                dfusm_pkg::REQ_GETSTATUS:
                begin
                    if (item.direction_in && item.length >= dfusm_pkg::GETSTATUS_MIN_LEN)
                    begin
                        case (state_reg)
                            dfusm_pkg::ST_DN_SYNC:
                            begin
                                state_next = dfusm_pkg::ST_DN_IDLE;
                            end
                            dfusm_pkg::ST_MAN_SYNC:
                            begin
                                status_next = dfusm_pkg::flash_to_status(item.flash_result);
                                if (item.flash_result != dfusm_pkg::FLASH_OK)
                                begin
                                    state_next = dfusm_pkg::ST_ERROR;
                                end
                                else
                                begin
                                    state_next = dfusm_pkg::ST_MAN;
                                    man_next   = 1'b1;
                                end
                            end
                            dfusm_pkg::ST_MAN:
                            begin
                                state_next = dfusm_pkg::ST_WAIT_RESET;
                            end
                            default:
                            begin
                                state_next = state_reg;
                            end
                        endcase
                    end
                end
                dfusm_pkg::REQ_CLRSTATUS, dfusm_pkg::REQ_ABORT:
                begin
                    if (!item.direction_in
                        && ((item.kind == dfusm_pkg::REQ_CLRSTATUS
                             && state_reg == dfusm_pkg::ST_ERROR)
                            || (item.kind == dfusm_pkg::REQ_ABORT && can_abort)))
                    begin
                        state_next  = dfusm_pkg::ST_IDLE;
                        status_next = dfusm_pkg::SC_OK;
                        hdr_next    = 1'b0;
                        man_next    = 1'b0;
                        off_next    = '0;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    // outputs: acceptance and the state as it stands after the item
    always_comb
    begin
        ok = 1'b0;
        if (item.class_interface_ok)
        begin
            case (item.kind)
                dfusm_pkg::REQ_DNLOAD:
                begin
                    if (!item.direction_in && state_reg != dfusm_pkg::ST_ERROR)
                    begin
                        if (item.length == 16'd0)
                        begin
                            ok = (state_reg == dfusm_pkg::ST_DN_IDLE) && hdr_reg;
                        end
                        else
                        begin
                            ok = (item.length <= XFER_LEN);
                        end
                    end
                end
                dfusm_pkg::REQ_GETSTATUS:
                begin
                    ok = item.direction_in && (item.length >= dfusm_pkg::GETSTATUS_MIN_LEN);
                end
                dfusm_pkg::REQ_CLRSTATUS:
                begin
                    ok = !item.direction_in && (state_reg == dfusm_pkg::ST_ERROR);
                end
                dfusm_pkg::REQ_GETSTATE:
                begin
                    ok = item.direction_in && (item.length >= dfusm_pkg::GETSTATE_MIN_LEN);
                end
                dfusm_pkg::REQ_ABORT:
                begin
                    ok = !item.direction_in && can_abort;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
        result.accepted      = ok;
        result.status_code   = 4'(status_next);
        result.state_code    = 3'(state_next);
        result.manifest_done = man_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dfusm_pkg::ST_IDLE;
            status_reg <= dfusm_pkg::SC_OK;
            hdr_reg    <= 1'b0;
            man_reg    <= 1'b0;
            off_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            hdr_reg    <= hdr_next;
            man_reg    <= man_next;
            off_reg    <= off_next;
        end
    end

endmodule

// File: rtl/core/dfusm_out_reg.sv
// Result register for response items.
// Depends on dfusm_pkg for the response item type.
module dfusm_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  dfusm_pkg::rsp_t  result,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output dfusm_pkg::rsp_t  rsp
);

    logic            vld_reg;
    logic            vld_next;
    dfusm_pkg::rsp_t rsp_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = vld_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/core/dfu_download_state_machine_top.sv
// DFU 1.1 download-side device state machine. Each request item is taken into an
// input register, decoded combinationally against the DFU state, and its response
// (accepted, status, state, manifest flag after the request) lands in a result
// register. One item per cycle sustained while the response side does not stall;
// the response passes through the input register and then the result register
// before it is valid. Request stall only rises when both registers are full and
// the response side stalls.
//
// Top level; instantiates dfusm_in_reg, dfusm_ctrl, dfusm_out_reg; uses dfusm_pkg.
module dfu_download_state_machine_top
#(
    parameter int unsigned MAX_BLOCK_LEN = dfusm_pkg::MAX_BLOCK_LEN_DEF,
    parameter int unsigned HEADER_SIZE   = dfusm_pkg::HEADER_SIZE_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  dfusm_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output dfusm_pkg::rsp_t  rsp
);

    logic            item_vld;
    logic            fire;
    dfusm_pkg::req_t item;
    dfusm_pkg::rsp_t result;

    // advance when the result register is free or draining this cycle
    assign fire = item_vld && (!rsp_valid || !rsp_stall);

    dfusm_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .advance   (fire),
        .item_vld  (item_vld),
        .item      (item)
    );

    dfusm_ctrl
    #(
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
        .HEADER_SIZE   (HEADER_SIZE)
    )
    u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    dfusm_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_no_advance_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> !fire)
        else $error("item advanced into a stalled result register");

    a_error_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.state_code == 3'(dfusm_pkg::ST_ERROR)) |->
            (rsp.status_code != 4'(dfusm_pkg::SC_OK)))
        else $error("error state reported with ok status");
`endif

endmodule
